@@ rtl/can_mrq_pkg.sv @@
// Shared definitions for the CAN message ring queue: field widths, queue
// depth, kind and status codes, the stored entry type and a pointer helper.
// No dependencies.
package can_mrq_pkg;

   localparam int unsigned QUEUE_DEPTH    = 16;
   localparam int unsigned PTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned ID_W           = 11;
   localparam int unsigned LEN_W          = 4;
   localparam int unsigned MAX_DATA_BYTES = 8;
   localparam int unsigned DATA_W         = 8 * MAX_DATA_BYTES;
   localparam int unsigned STATUS_W       = 2;

   // Item kind
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERWRITE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] bytes;
   } entry_type;

   // Advance a ring pointer, wrapping from the last slot back to zero.
   function automatic ptr_type next_ptr(input ptr_type ptr);
      ptr_type result;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

endpackage

@@ rtl/can_mrq_if.sv @@
// Handshake channels of the CAN message ring queue: request (push or pop)
// and response. Depends on can_mrq_pkg.
interface can_mrq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [can_mrq_pkg::ID_W-1:0]       msg_id;
   logic [can_mrq_pkg::LEN_W-1:0]      msg_len;
   logic [can_mrq_pkg::DATA_W-1:0]     msg_bytes;

   modport source (output valid, kind, msg_id, msg_len, msg_bytes, input ready);
   modport sink   (input valid, kind, msg_id, msg_len, msg_bytes, output ready);
endinterface

interface can_mrq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [can_mrq_pkg::STATUS_W-1:0]   status;
   logic [can_mrq_pkg::ID_W-1:0]       out_id;
   logic [can_mrq_pkg::LEN_W-1:0]      out_len;
   logic [can_mrq_pkg::DATA_W-1:0]     out_bytes;

   modport source (output valid, status, out_id, out_len, out_bytes, input ready);
   modport sink   (input valid, status, out_id, out_len, out_bytes, output ready);
endinterface

@@ rtl/can_message_ring_queue_top.sv @@
// CAN message ring queue: one item (push or pop) in, one result item out.
// The result of an item is registered, valid in the cycle after it is accepted.
// One item per cycle while results drain; the response register frees as taken.
// Reset (synchronous, active high) empties the queue and clears the pointers;
// the message store itself is not cleared, as the fill count guards every read.
// Depends on can_mrq_pkg and can_mrq_if.
module can_message_ring_queue_top (
   input logic           clock,
   input logic           reset,
   can_mrq_req_if.sink   req,
   can_mrq_rsp_if.source rsp
);

   // ---------------------------------------------------------------------
   // Queue control state
   // ---------------------------------------------------------------------
   can_mrq_pkg::ptr_type write_ptr_ff, write_ptr_in;
   can_mrq_pkg::ptr_type read_ptr_ff,  read_ptr_in;
   can_mrq_pkg::cnt_type fill_count_ff, fill_count_in;

   // Response stage
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [can_mrq_pkg::STATUS_W-1:0]    status_ff, status_in;
   can_mrq_pkg::entry_type              rd_entry_ff;

   // Message store: written at the head, read at the tail
   can_mrq_pkg::entry_type              mem [can_mrq_pkg::QUEUE_DEPTH];

   logic                                accept;
   logic                                is_push;
   logic                                is_pop;
   logic                                empty;
   logic                                full;
   logic                                pop_hit;
   logic [can_mrq_pkg::LEN_W-1:0]       len_sat;
   can_mrq_pkg::entry_type              wr_entry;

   // Take a new item whenever the response register is empty or being drained.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign is_push   = (req.kind == can_mrq_pkg::KIND_PUSH);
   assign is_pop    = (req.kind == can_mrq_pkg::KIND_POP);
   assign empty     = (fill_count_ff == '0);
   assign full      = (fill_count_ff == can_mrq_pkg::CNT_W'(can_mrq_pkg::QUEUE_DEPTH));
   assign pop_hit   = is_pop && !empty;

   // Saturate the byte count to eight and clear bytes at or beyond it, so a
   // later pop can return the stored word as it stands.
   always_comb begin
      if (req.msg_len > can_mrq_pkg::LEN_W'(can_mrq_pkg::MAX_DATA_BYTES)) begin
         len_sat = can_mrq_pkg::LEN_W'(can_mrq_pkg::MAX_DATA_BYTES);
      end else begin
         len_sat = req.msg_len;
      end
      wr_entry.id  = req.msg_id;
      wr_entry.len = len_sat;
      for (int b = 0; b < int'(can_mrq_pkg::MAX_DATA_BYTES); b++) begin
         if (can_mrq_pkg::LEN_W'(b) < len_sat) begin
            wr_entry.bytes[8*b +: 8] = req.msg_bytes[8*b +: 8];
         end else begin
            wr_entry.bytes[8*b +: 8] = 8'h00;
         end
      end
   end

   // Pointer and fill-count update for the accepted item.
   always_comb begin
      write_ptr_in  = write_ptr_ff;
      read_ptr_in   = read_ptr_ff;
      fill_count_in = fill_count_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = can_mrq_pkg::STATUS_OK;
         if (is_push) begin
            write_ptr_in = can_mrq_pkg::next_ptr(write_ptr_ff);
            if (full) begin
               // drop the oldest entry: advance the tail, hold the count
               read_ptr_in = can_mrq_pkg::next_ptr(read_ptr_ff);
               status_in   = can_mrq_pkg::STATUS_OVERWRITE;
            end else begin
               fill_count_in = fill_count_ff + 1'b1;
            end
         end else if (empty) begin
            status_in = can_mrq_pkg::STATUS_EMPTY;
         end else begin
            read_ptr_in   = can_mrq_pkg::next_ptr(read_ptr_ff);
            fill_count_in = fill_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff  <= '0;
         read_ptr_ff   <= '0;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         status_ff     <= can_mrq_pkg::STATUS_OK;
      end else begin
         write_ptr_ff  <= write_ptr_in;
         read_ptr_ff   <= read_ptr_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         status_ff     <= status_in;
      end
   end

   // Store write on push; registered read on pop. A push and a pop never
   // share a cycle, and a pop in the cycle after a push sees the new entry.
   always_ff @(posedge clock) begin
      if (accept && is_push) begin
         mem[write_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (pop_hit) begin
            rd_entry_ff <= mem[read_ptr_ff];
         end else begin
            // push results and empty pops carry zero fields
            rd_entry_ff <= '0;
         end
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = status_ff;
   assign rsp.out_id    = rd_entry_ff.id;
   assign rsp.out_len   = rd_entry_ff.len;
   assign rsp.out_bytes = rd_entry_ff.bytes;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= can_mrq_pkg::CNT_W'(can_mrq_pkg::QUEUE_DEPTH))
      else $error("fill count above queue depth");

   a_ptrs_meet : assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (write_ptr_ff == read_ptr_ff))
      else $error("pointers disagree with empty or full count");

   a_empty_pop : assert property (@(posedge clock) disable iff (reset)
      (accept && is_pop && empty) |=>
         (rsp_valid_ff && status_ff == can_mrq_pkg::STATUS_EMPTY && rd_entry_ff == '0))
      else $error("pop of empty queue not reported as empty");

   a_overwrite : assert property (@(posedge clock) disable iff (reset)
      (accept && is_push && full) |=>
         (status_ff == can_mrq_pkg::STATUS_OVERWRITE && full &&
          read_ptr_ff == can_mrq_pkg::next_ptr($past(read_ptr_ff))))
      else $error("push onto full queue did not drop the oldest entry");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(fill_count_ff) && $stable(write_ptr_ff) && $stable(read_ptr_ff))
      else $error("queue state moved without an accepted item");

endmodule

@@ tb/can_message_ring_queue_top_tb.sv @@
// Self-checking testbench for the CAN message ring queue: drives push and pop
// items, predicts every result with a behavioural ring and checks it field by field.
// Depends on can_mrq_pkg, can_mrq_if and can_message_ring_queue_top.
module can_message_ring_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One request item as the driver presents it
   typedef struct packed {
      logic                           kind;
      logic [can_mrq_pkg::ID_W-1:0]   id;
      logic [can_mrq_pkg::LEN_W-1:0]  len;
      logic [can_mrq_pkg::DATA_W-1:0] bytes;
   } can_op_type;

   // One response item, in the order of the response channel fields
   typedef struct packed {
      logic [can_mrq_pkg::STATUS_W-1:0] status;
      logic [can_mrq_pkg::ID_W-1:0]     id;
      logic [can_mrq_pkg::LEN_W-1:0]    len;
      logic [can_mrq_pkg::DATA_W-1:0]   bytes;
   } can_result_type;

   logic clock;
   logic reset;

   can_mrq_req_if req_ch ();
   can_mrq_rsp_if rsp_ch ();

   can_message_ring_queue_top DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Stimulus waiting for the driver, and results waiting for the response channel
   can_op_type     pending_ops[$];
   can_result_type awaited_results[$];

   int unsigned ops_queued    = 0;
   int unsigned ops_accepted  = 0;
   int unsigned error_count   = 0;
   int unsigned send_idle_pct = 19;
   int unsigned recv_idle_pct = 52;
   bit          req_fired     = 1'b0;

   // Behavioural copy of the ring: message slots, head (next write), tail (oldest)
   // and fill level. Reset happens once, at the start, so initialise here.
   can_mrq_pkg::entry_type ring_slot [can_mrq_pkg::QUEUE_DEPTH];
   can_mrq_pkg::ptr_type   ring_head = '0;
   can_mrq_pkg::ptr_type   ring_tail = '0;
   int unsigned            ring_fill = 0;

   // Apply one accepted item to the ring and return the result it must produce.
   function automatic can_result_type predict_queue_result(input can_op_type op);
      can_result_type                 res;
      logic [can_mrq_pkg::LEN_W-1:0]  keep_len;
      logic [can_mrq_pkg::DATA_W-1:0] keep_mask;
      res = '{status: can_mrq_pkg::STATUS_OK, id: '0, len: '0, bytes: '0};
      if (op.kind == can_mrq_pkg::KIND_PUSH) begin
         // Saturate the length at eight bytes and clear the bytes beyond it
         keep_len  = (op.len > can_mrq_pkg::LEN_W'(can_mrq_pkg::MAX_DATA_BYTES))
                     ? can_mrq_pkg::LEN_W'(can_mrq_pkg::MAX_DATA_BYTES) : op.len;
         keep_mask = (keep_len >= can_mrq_pkg::LEN_W'(can_mrq_pkg::MAX_DATA_BYTES))
                     ? '1
                     : ((can_mrq_pkg::DATA_W'(1) << (8 * keep_len))
                        - can_mrq_pkg::DATA_W'(1));
         ring_slot[ring_head] = '{id: op.id, len: keep_len, bytes: op.bytes & keep_mask};
         ring_head = can_mrq_pkg::next_ptr(ring_head);
         if (ring_fill == can_mrq_pkg::QUEUE_DEPTH) begin
            // Full: drop the oldest message by advancing the tail
            ring_tail  = can_mrq_pkg::next_ptr(ring_tail);
            res.status = can_mrq_pkg::STATUS_OVERWRITE;
         end else begin
            ring_fill++;
         end
      end else if (ring_fill == 0) begin
         res.status = can_mrq_pkg::STATUS_EMPTY;
      end else begin
         res.id    = ring_slot[ring_tail].id;
         res.len   = ring_slot[ring_tail].len;
         res.bytes = ring_slot[ring_tail].bytes;
         ring_tail = can_mrq_pkg::next_ptr(ring_tail);
         ring_fill--;
      end
      return res;
   endfunction

   task automatic check_field(input string field,
                              input logic [can_mrq_pkg::DATA_W-1:0] want,
                              input logic [can_mrq_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         error_count++;
      end
   endtask

   task automatic add_op(input logic kind, input logic [can_mrq_pkg::ID_W-1:0] id,
                         input logic [can_mrq_pkg::LEN_W-1:0] len,
                         input logic [can_mrq_pkg::DATA_W-1:0] bytes);
      pending_ops.push_back('{kind: kind, id: id, len: len, bytes: bytes});
      ops_queued++;
   endtask

   // Random content with lengths mostly in the legal range, the rest saturating.
   task automatic add_random_op(input logic kind);
      logic [can_mrq_pkg::LEN_W-1:0] len;
      len = ($urandom_range(99) < 75)
            ? can_mrq_pkg::LEN_W'($urandom_range(can_mrq_pkg::MAX_DATA_BYTES))
            : can_mrq_pkg::LEN_W'($urandom_range(15, can_mrq_pkg::MAX_DATA_BYTES + 1));
      add_op(kind, can_mrq_pkg::ID_W'($urandom), len, {$urandom, $urandom});
   endtask

   // Bursts leaning towards pushes fill the ring and overwrite; bursts leaning
   // towards pops drain it and hit the empty case; mixed bursts hover in between.
   task automatic add_random_phase(input int unsigned count);
      int unsigned left;
      int unsigned burst;
      int unsigned push_pct;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(40, 8);
         if (burst > left) burst = left;
         case ($urandom_range(2))
            0: begin
               push_pct = 85;
            end
            1: begin
               push_pct = 15;
            end
            default: begin
               push_pct = 50;
            end
         endcase
         repeat (burst) begin
            add_random_op(($urandom_range(99) < push_pct) ? can_mrq_pkg::KIND_PUSH
                                                          : can_mrq_pkg::KIND_POP);
         end
         left -= burst;
      end
   endtask

   // Clock: 10 ns period
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: change inputs on the falling edge. Hold an item until it is taken,
   // then load the next one or idle at the rate of the current phase.
   always @(negedge clock) begin
      can_op_type next_op;
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.kind      <= can_mrq_pkg::KIND_PUSH;
         req_ch.msg_id    <= '0;
         req_ch.msg_len   <= '0;
         req_ch.msg_bytes <= '0;
         rsp_ch.ready     <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (!req_ch.valid || req_fired) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_op = pending_ops.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.kind      <= next_op.kind;
               req_ch.msg_id    <= next_op.id;
               req_ch.msg_len   <= next_op.len;
               req_ch.msg_bytes <= next_op.bytes;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: sample both channels on the rising edge. Check a taken result
   // against the oldest expectation first, then predict for a taken item; a
   // result can never belong to an item taken on the same edge.
   always @(posedge clock) begin
      can_result_type got;
      can_result_type want;
      can_op_type     taken;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{status: rsp_ch.status, id: rsp_ch.out_id, len: rsp_ch.out_len,
                    bytes: rsp_ch.out_bytes};
            if (awaited_results.size() == 0) begin
               $error("result item with no expectation waiting: 0x%0h", got);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", can_mrq_pkg::DATA_W'(want.status),
                           can_mrq_pkg::DATA_W'(got.status));
               check_field("out_id", can_mrq_pkg::DATA_W'(want.id),
                           can_mrq_pkg::DATA_W'(got.id));
               check_field("out_len", can_mrq_pkg::DATA_W'(want.len),
                           can_mrq_pkg::DATA_W'(got.len));
               check_field("out_bytes", want.bytes, got.bytes);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            taken = '{kind: req_ch.kind, id: req_ch.msg_id, len: req_ch.msg_len,
                      bytes: req_ch.msg_bytes};
            awaited_results.push_back(predict_queue_result(taken));
            ops_accepted++;
            req_fired = 1'b1;
         end else begin
            req_fired = 1'b0;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      reset = 1'b1;

      // Pop of an empty queue, junk in the ignored fields
      add_op(can_mrq_pkg::KIND_POP, '1, '1, '1);
      // Eighteen pushes: fill the ring, wrap the head, overwrite twice.
      // Lengths sweep 15 down to 0 (saturation above eight, zero-length), and
      // all-ones data on every other push shows the clearing of unused bytes.
      for (int i = 0; i < 18; i++) begin
         add_op(can_mrq_pkg::KIND_PUSH,
                (i == 0) ? can_mrq_pkg::ID_W'(0)
                         : (i == 1) ? {can_mrq_pkg::ID_W{1'b1}}
                                    : can_mrq_pkg::ID_W'($urandom),
                (i < 16) ? can_mrq_pkg::LEN_W'(15 - i)
                         : can_mrq_pkg::LEN_W'(can_mrq_pkg::MAX_DATA_BYTES),
                (i % 2 == 0) ? {can_mrq_pkg::DATA_W{1'b1}} : {$urandom, $urandom});
      end
      // Drain a few from the moved tail
      repeat (6) begin
         add_op(can_mrq_pkg::KIND_POP, can_mrq_pkg::ID_W'($urandom),
                can_mrq_pkg::LEN_W'($urandom), {$urandom, $urandom});
      end

      add_random_phase(430);

      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Phase one: sender idles lightly, receiver heavily
      while (ops_accepted != ops_queued) @(negedge clock);

      // Phase two: swap the idle rates
      send_idle_pct = 52;
      recv_idle_pct = 19;
      add_random_phase(430);
      while (ops_accepted != ops_queued) @(negedge clock);

      // Phase three: full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_phase(440);
      while (ops_accepted != ops_queued || awaited_results.size() != 0) @(negedge clock);

      // Allow time for any stray result to show up
      repeat (10) @(negedge clock);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("can_message_ring_queue_top_tb: PASS");
      end else begin
         $display("can_message_ring_queue_top_tb: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2ms;
      $display("can_message_ring_queue_top_tb: FAIL");
      $finish;
   end

endmodule
